// ===== design/timestamp_duration_calc_top_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef TIMESTAMP_DURATION_CALC_TOP_DEFINES_SVH
`define TIMESTAMP_DURATION_CALC_TOP_DEFINES_SVH

// Implication check, sampled on the rising clock edge, off while in reset.
`define TDC_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// Condition that must never be seen out of reset.
`define TDC_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== design/tdc_pkg.sv =====
`default_nettype none

package tdc_pkg;

  // Cycles from an accepted transaction to its result strobe.
  localparam int unsigned LATENCY = 10;

  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam logic [21:0] DAYS_MAX     = 22'h3FFFFF;

  // floor(2^20 / 100): quotient estimate is exact or one low for 14-bit values
  localparam logic [13:0] RECIP100 = 14'd10485;
  // floor(2^22 / 60): quotient estimate is exact or one low below 2^17
  localparam logic [16:0] RECIP60  = 17'd69905;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } stamp_t;

  typedef struct packed {
    logic [5:0]  first_second;
    logic [5:0]  first_minute;
    logic [4:0]  first_hour;
    logic [4:0]  first_day;
    logic [3:0]  first_month;
    logic [13:0] first_year;
    logic [5:0]  second_second;
    logic [5:0]  second_minute;
    logic [4:0]  second_hour;
    logic [4:0]  second_day;
    logic [3:0]  second_month;
    logic [13:0] second_year;
  } in_t;

  typedef struct packed {
    logic [21:0] diff_days;
    logic [4:0]  diff_hours;
    logic [5:0]  diff_minutes;
    logic [5:0]  diff_seconds;
  } out_t;

  // Normalized difference handed from the subtractor to the splitter.
  typedef struct packed {
    logic        valid;
    logic        sat;
    logic [21:0] days;
    logic [16:0] rest;
  } norm_t;

  // Days in the year before the first of the given month (month 1..12).
  function automatic logic [8:0] days_before(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/tdc_stamp.sv =====
`default_nettype none

// Timestamp to day count and second of day, three stages.
module tdc_stamp (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire tdc_pkg::stamp_t stamp_i,
  output logic                 valid_o,
  output logic [22:0]          days_o,
  output logic [16:0]          tod_o
);

  // stage 1: clamp, quotient estimates by 100, hour*60+minute
  logic [3:0]  mon_c;
  logic [13:0] yr_c;
  logic [13:0] prior_c;

  logic        v1_q;
  logic [13:0] yr1_q, pr1_q;
  logic [27:0] yest1_q, pest1_q;
  logic [3:0]  mon1_q;
  logic [4:0]  day1_q;
  logic [10:0] hm1_q;
  logic [5:0]  sec1_q;

  always_comb begin
    if (stamp_i.month == 4'd0) begin
      mon_c = 4'd1;
    end else if (stamp_i.month > 4'd12) begin
      mon_c = 4'd12;
    end else begin
      mon_c = stamp_i.month;
    end
    yr_c    = (stamp_i.year == 14'd0) ? 14'd1 : stamp_i.year;
    prior_c = yr_c - 14'd1;
  end

  // stage 2: correct quotients, leap flag, prior*365, second of day
  logic [7:0]  yq0, pq0, yq, pq;
  logic [13:0] yrem0, prem0, yrem;
  logic        leap_c;

  logic        v2_q;
  logic [22:0] p365_q;
  logic [11:0] p4_q;
  logic [7:0]  pq100_q;
  logic [5:0]  pq400_q;
  logic [3:0]  mon2_q;
  logic [4:0]  day2_q;
  logic        leap2_q;
  logic [16:0] tod2_q;

  always_comb begin
    yq0   = yest1_q[27:20];
    pq0   = pest1_q[27:20];
    yrem0 = yr1_q - {6'd0, yq0} * 14'd100;
    prem0 = pr1_q - {6'd0, pq0} * 14'd100;
    if (yrem0 >= 14'd100) begin
      yq   = yq0 + 8'd1;
      yrem = yrem0 - 14'd100;
    end else begin
      yq   = yq0;
      yrem = yrem0;
    end
    pq     = (prem0 >= 14'd100) ? pq0 + 8'd1 : pq0;
    leap_c = (yr1_q[1:0] == 2'd0) && ((yrem != 14'd0) || (yq[1:0] == 2'd0));
  end

  // stage 3: sum of the day count
  logic        v3_q;
  logic [22:0] days3_q;
  logic [16:0] tod3_q;
  logic [22:0] days_c;

  always_comb begin
    days_c = p365_q + {11'd0, p4_q} - {15'd0, pq100_q} + {17'd0, pq400_q}
           + {14'd0, tdc_pkg::days_before(mon2_q)} + {18'd0, day2_q}
           + {22'd0, leap2_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    yr1_q   <= yr_c;
    pr1_q   <= prior_c;
    yest1_q <= 28'(yr_c) * 28'(tdc_pkg::RECIP100);
    pest1_q <= 28'(prior_c) * 28'(tdc_pkg::RECIP100);
    mon1_q  <= mon_c;
    day1_q  <= stamp_i.day;
    hm1_q   <= {6'd0, stamp_i.hour} * 11'd60 + {5'd0, stamp_i.min};
    sec1_q  <= stamp_i.sec;

    p365_q  <= {9'd0, pr1_q} * 23'd365;
    p4_q    <= pr1_q[13:2];
    pq100_q <= pq;
    pq400_q <= pq[7:2];
    mon2_q  <= mon1_q;
    day2_q  <= day1_q;
    leap2_q <= leap_c && (mon1_q > 4'd2);
    tod2_q  <= {6'd0, hm1_q} * 17'd60 + {11'd0, sec1_q};

    days3_q <= days_c;
    tod3_q  <= tod2_q;
  end

  assign valid_o = v3_q;
  assign days_o  = days3_q;
  assign tod_o   = tod3_q;

endmodule

`default_nettype wire

// ===== design/tdc_diff.sv =====
`default_nettype none

// Signed difference, day borrow into [0, 86400), magnitude. Three stages.
module tdc_diff (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [22:0] days_a_i,
  input  wire logic [16:0] tod_a_i,
  input  wire logic [22:0] days_b_i,
  input  wire logic [16:0] tod_b_i,
  output tdc_pkg::norm_t   norm_o
);

  // two's complement differences
  logic        v4_q;
  logic [23:0] dd4_q;
  logic [17:0] dt4_q;

  // stage 5: move the second difference into [0, 86400)
  logic [18:0] dt_w, dt_p1;
  logic [18:0] rest_c;
  logic [23:0] dd_c;

  always_comb begin
    dt_w  = {dt4_q[17], dt4_q};
    dt_p1 = dt_w + 19'(tdc_pkg::SECS_PER_DAY);
    if (dt_p1[18]) begin
      rest_c = dt_p1 + 19'(tdc_pkg::SECS_PER_DAY);
      dd_c   = dd4_q - 24'd2;
    end else if (dt_w[18]) begin
      rest_c = dt_p1;
      dd_c   = dd4_q - 24'd1;
    end else if (dt_w >= 19'(tdc_pkg::SECS_PER_DAY)) begin
      rest_c = dt_w - 19'(tdc_pkg::SECS_PER_DAY);
      dd_c   = dd4_q + 24'd1;
    end else begin
      rest_c = dt_w;
      dd_c   = dd4_q;
    end
  end

  logic        v5_q;
  logic [23:0] dd5_q;
  logic [16:0] rest5_q;

  // stage 6: absolute value of days*86400 + rest
  logic [23:0] mag_c;
  logic [16:0] rabs_c;

  always_comb begin
    if (!dd5_q[23]) begin
      mag_c  = dd5_q;
      rabs_c = rest5_q;
    end else if (rest5_q == 17'd0) begin
      mag_c  = ~dd5_q + 24'd1;
      rabs_c = 17'd0;
    end else begin
      mag_c  = ~dd5_q;
      rabs_c = tdc_pkg::SECS_PER_DAY - rest5_q;
    end
  end

  logic        v6_q;
  logic        sat6_q;
  logic [21:0] days6_q;
  logic [16:0] rest6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dd4_q   <= {1'b0, days_a_i} - {1'b0, days_b_i};
    dt4_q   <= {1'b0, tod_a_i} - {1'b0, tod_b_i};
    dd5_q   <= dd_c;
    rest5_q <= rest_c[16:0];
    sat6_q  <= (mag_c[23:22] != 2'd0);
    days6_q <= mag_c[21:0];
    rest6_q <= rabs_c;
  end

  always_comb begin
    norm_o.valid = v6_q;
    norm_o.sat   = sat6_q;
    norm_o.days  = days6_q;
    norm_o.rest  = rest6_q;
  end

endmodule

`default_nettype wire

// ===== design/tdc_split.sv =====
`default_nettype none

// Second of day into hours, minutes, seconds by reciprocal multiply. Four stages.
module tdc_split (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tdc_pkg::norm_t norm_i,
  output logic                valid_o,
  output tdc_pkg::out_t       result_o
);

  // stage 7: estimate rest / 60
  logic        v7_q, sat7_q;
  logic [21:0] days7_q;
  logic [16:0] rest7_q;
  logic [33:0] est7_q;

  // stage 8: correct, split off seconds
  logic [10:0] q0_c, mtot_c;
  logic [16:0] r0_c, r_c;

  always_comb begin
    q0_c = est7_q[32:22];
    r0_c = rest7_q - {6'd0, q0_c} * 17'd60;
    if (r0_c >= 17'd60) begin
      mtot_c = q0_c + 11'd1;
      r_c    = r0_c - 17'd60;
    end else begin
      mtot_c = q0_c;
      r_c    = r0_c;
    end
  end

  logic        v8_q, sat8_q;
  logic [21:0] days8_q;
  logic [10:0] mtot8_q;
  logic [5:0]  sec8_q;

  // stage 9: estimate minutes / 60
  logic        v9_q, sat9_q;
  logic [21:0] days9_q;
  logic [10:0] mtot9_q;
  logic [5:0]  sec9_q;
  logic [27:0] est9_q;

  // stage 10: correct, hours and minutes, saturation
  logic [4:0]  h0_c, h_c;
  logic [10:0] m0_c, m_c;
  tdc_pkg::out_t res_c;

  always_comb begin
    h0_c = est9_q[26:22];
    m0_c = mtot9_q - {6'd0, h0_c} * 11'd60;
    if (m0_c >= 11'd60) begin
      h_c = h0_c + 5'd1;
      m_c = m0_c - 11'd60;
    end else begin
      h_c = h0_c;
      m_c = m0_c;
    end
    if (sat9_q) begin
      res_c.diff_days    = tdc_pkg::DAYS_MAX;
      res_c.diff_hours   = 5'd23;
      res_c.diff_minutes = 6'd59;
      res_c.diff_seconds = 6'd59;
    end else begin
      res_c.diff_days    = days9_q;
      res_c.diff_hours   = h_c;
      res_c.diff_minutes = m_c[5:0];
      res_c.diff_seconds = sec9_q;
    end
  end

  logic          v10_q;
  tdc_pkg::out_t res10_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else begin
      v7_q  <= norm_i.valid;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sat7_q  <= norm_i.sat;
    days7_q <= norm_i.days;
    rest7_q <= norm_i.rest;
    est7_q  <= {17'd0, norm_i.rest} * 34'(tdc_pkg::RECIP60);

    sat8_q  <= sat7_q;
    days8_q <= days7_q;
    mtot8_q <= mtot_c;
    sec8_q  <= r_c[5:0];

    sat9_q  <= sat8_q;
    days9_q <= days8_q;
    mtot9_q <= mtot8_q;
    sec9_q  <= sec8_q;
    est9_q  <= {17'd0, mtot8_q} * 28'(tdc_pkg::RECIP60);

    res10_q <= res_c;
  end

  assign valid_o  = v10_q;
  assign result_o = res10_q;

endmodule

`default_nettype wire

// ===== design/timestamp_duration_calc_top.sv =====
// Absolute time between two calendar timestamps, as days/hours/minutes/seconds.
//
// Command channel: drive cmd_i and raise start_i; the transaction is taken at
// every rising edge where start_i is high and busy_o is low. busy_o is always
// low, so a new pair of timestamps can be issued on every clock cycle.
// Result channel: result_o is valid for exactly one cycle while
// result_valid_o is high. There is no back-pressure; the receiver must take
// each result in that cycle.
// Throughput: one transaction per cycle, set by the fully pipelined
// datapath (3 stages per timestamp conversion, 3 for difference and day
// borrow, 4 for the constant divisions by 60).
// Out-of-range month is clamped to 1..12, year 0 is taken as year 1; a day
// count above 22 bits returns all-ones days with 23:59:59.
// Reset (rst_ni low, asynchronous) clears all valid bits; transactions in
// flight are dropped and no result strobe is seen until new ones arrive.
`default_nettype none

module timestamp_duration_calc_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire tdc_pkg::in_t  cmd_i,
  output logic               busy_o,
  output logic               result_valid_o,
  output tdc_pkg::out_t      result_o
);

  // Never stalls: each stage moves on every cycle.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  tdc_pkg::stamp_t stamp_a, stamp_b;

  always_comb begin
    stamp_a.sec   = cmd_i.first_second;
    stamp_a.min   = cmd_i.first_minute;
    stamp_a.hour  = cmd_i.first_hour;
    stamp_a.day   = cmd_i.first_day;
    stamp_a.month = cmd_i.first_month;
    stamp_a.year  = cmd_i.first_year;
    stamp_b.sec   = cmd_i.second_second;
    stamp_b.min   = cmd_i.second_minute;
    stamp_b.hour  = cmd_i.second_hour;
    stamp_b.day   = cmd_i.second_day;
    stamp_b.month = cmd_i.second_month;
    stamp_b.year  = cmd_i.second_year;
  end

  logic        va, vb;
  logic [22:0] days_a, days_b;
  logic [16:0] tod_a, tod_b;

  // Both converters run in lockstep; their valid bits are always equal.
  tdc_stamp u_stamp_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .stamp_i (stamp_a),
    .valid_o (va),
    .days_o  (days_a),
    .tod_o   (tod_a)
  );

  tdc_stamp u_stamp_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .stamp_i (stamp_b),
    .valid_o (vb),
    .days_o  (days_b),
    .tod_o   (tod_b)
  );

  tdc_pkg::norm_t norm;

  // Difference in (days, second-of-day) form; avoids a 40-bit seconds count.
  tdc_diff u_diff (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (va && vb),
    .days_a_i (days_a),
    .tod_a_i  (tod_a),
    .days_b_i (days_b),
    .tod_b_i  (tod_b),
    .norm_o   (norm)
  );

  tdc_split u_split (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .norm_i   (norm),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ===== design/tdc_checker.sv =====
`default_nettype none

`include "timestamp_duration_calc_top_defines.svh"

module tdc_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire logic          busy_o,
  input wire logic          result_valid_o,
  input wire tdc_pkg::out_t result_o
);

  `TDC_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy_o, "busy raised on a stall-free pipe")

  `TDC_ASSERT_IMPL(a_result_follows, clk_i, rst_ni, start_i && !busy_o, ##(tdc_pkg::LATENCY) result_valid_o, "accepted transaction produced no result")

  `TDC_ASSERT_IMPL(a_no_spurious, clk_i, rst_ni, result_valid_o, $past(start_i && !busy_o && rst_ni, tdc_pkg::LATENCY), "result strobe without a transaction")

  `TDC_ASSERT_IMPL(a_fields_in_range, clk_i, rst_ni, result_valid_o, (result_o.diff_hours <= 5'd23 && result_o.diff_minutes <= 6'd59 && result_o.diff_seconds <= 6'd59), "time-of-day fields out of range")

endmodule

bind timestamp_duration_calc_top tdc_checker u_tdc_checker (.*);

`default_nettype wire
